// File: sv/dlr_pkg.sv
// ----------------------------------------------------------------------------
// dlr_pkg
// Shared types, constants and helpers for the display line refresher.
// ----------------------------------------------------------------------------
`default_nettype none

package dlr_pkg;

  localparam int DLR_STRING_LENGTH = 16;

  localparam int POS_W   = 5;
  localparam int COL_W   = 6;
  localparam int ROW_W   = 3;
  localparam int CHAR_W  = 7;
  localparam int VAL_W   = 32;
  localparam int DIG_N   = 10;
  localparam int DCNT_W  = 4;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 16;

  localparam logic [COL_W-1:0] FIRST_COLUMN = 6'd24;
  localparam logic [COL_W-1:0] BLANK_OFFSET = 6'd23;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // floor(n / 10) == (n * DIV10_RECIP) >> DIV10_SHIFT for every 32-bit n
  localparam logic [VAL_W-1:0] DIV10_RECIP = 32'hcccc_cccd;
  localparam int               DIV10_SHIFT = 35;

  typedef logic [1:0] line_t;
  localparam line_t LINE_STEPS = 2'd0;
  localparam line_t LINE_SPEED = 2'd1;
  localparam line_t LINE_ANGLE = 2'd2;
  localparam line_t LINE_NONE  = 2'd3;

  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_NOTICE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_CONV,
    ST_WRITE
  } state_t;

  typedef enum logic [1:0] {
    DU_IDLE,
    DU_MUL,
    DU_SUB
  } du_state_t;

  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] value;
  } du_cmd_t;

  typedef struct packed {
    logic       busy;
    logic       digit_vld;
    logic       last;
    logic [3:0] digit;
  } du_stat_t;

  function automatic logic [ROW_W-1:0] line_row(input line_t line);
    logic [ROW_W-1:0] r;
    unique case (line)
      LINE_STEPS: r = 3'd5;
      LINE_SPEED: r = 3'd7;
      LINE_ANGLE: r = 3'd6;
      default:    r = 3'd5;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/dlr_text_mem.sv
// ----------------------------------------------------------------------------
// dlr_text_mem
// Character store for all lines: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dlr_text_mem #(
  parameter int DEPTH  = 48,
  parameter int ADDR_W = 6
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [7:0]        wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [7:0]        rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: sv/dlr_digit_unit.sv
// ----------------------------------------------------------------------------
// dlr_digit_unit
// Shared divide-by-ten unit: peels decimal digits off a magnitude, least
// significant first, one digit per multiply-then-subtract pass.
// ----------------------------------------------------------------------------
`default_nettype none

module dlr_digit_unit
  import dlr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire du_cmd_t cmd,
  output du_stat_t     stat
);

  du_state_t          state_r, state_nxt;
  logic [VAL_W-1:0]   mag_r, mag_nxt;
  logic [2*VAL_W-1:0] prod_r;
  logic [VAL_W-1:0]   quot;
  logic [VAL_W-1:0]   rem;

  assign quot = VAL_W'(prod_r[2*VAL_W-1:DIV10_SHIFT]);
  assign rem  = mag_r - ((quot << 3) + (quot << 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      DU_IDLE: if (cmd.start) state_nxt = DU_MUL;
      DU_MUL:  state_nxt = DU_SUB;
      DU_SUB:  state_nxt = (quot == '0) ? DU_IDLE : DU_MUL;
      default: state_nxt = DU_IDLE;
    endcase
  end

  always_comb begin
    mag_nxt        = mag_r;
    stat.busy      = (state_r != DU_IDLE);
    stat.digit_vld = 1'b0;
    stat.last      = 1'b0;
    stat.digit     = rem[3:0];
    unique case (state_r)
      DU_IDLE: begin
        if (cmd.start) begin
          mag_nxt = cmd.value[VAL_W-1] ? (VAL_W'(0) - cmd.value) : cmd.value;
        end
      end
      DU_MUL: begin
      end
      DU_SUB: begin
        stat.digit_vld = 1'b1;
        stat.last      = (quot == '0);
        mag_nxt        = quot;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DU_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    prod_r <= {{VAL_W{1'b0}}, mag_r} * {{VAL_W{1'b0}}, DIV10_RECIP};
  end

endmodule

`default_nettype wire

// File: sv/display_line_refresher.sv
// Tick writing a character or a blank: accepted, then the emit state registers
// the result once the output is free. Do-nothing tick, every notice: no result.
// Tick that converts: the shared divide-by-ten unit produces each decimal digit,
// then each character is written to the store; ready stays low meanwhile.
// Synchronous active-low reset; strings empty, both pending flags set, steps line
// first. The character store needs no clearing: per-line lengths gate its reads.
// ----------------------------------------------------------------------------
// display_line_refresher
// Round-robin refresher of three numeric text lines, at most one character per tick.
// ----------------------------------------------------------------------------
`default_nettype none

module display_line_refresher
  import dlr_pkg::*;
#(
  parameter int STRING_LENGTH = DLR_STRING_LENGTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [31:0] new_speed, [63:32] step_count, [95:64] angle_degrees
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] op
  input  wire logic                   in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [5:0] column, [8:6] row, [15:9] character
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  localparam int DEPTH  = 3 * STRING_LENGTH;
  localparam int ADDR_W = $clog2(DEPTH);

  state_t            state_r, state_nxt;
  line_t             line_sel_r, line_sel_nxt;
  line_t             cur_line_r, cur_line_nxt;
  logic [POS_W-1:0]  wpos_r [3];
  logic [POS_W-1:0]  wpos_nxt [3];
  logic [POS_W-1:0]  slen_r [3];
  logic [POS_W-1:0]  slen_nxt [3];
  logic [POS_W-1:0]  clen_r [3];
  logic [POS_W-1:0]  clen_nxt [3];
  logic              steps_pend_r, steps_pend_nxt;
  logic              angle_pend_r, angle_pend_nxt;
  logic [VAL_W-1:0]  speed_r, speed_nxt;
  logic              neg_r, neg_nxt;
  logic [3:0]        dig_r [DIG_N];
  logic [3:0]        dig_nxt [DIG_N];
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [POS_W-1:0]  wr_pos_r, wr_pos_nxt;
  logic [COL_W-1:0]  res_col_r, res_col_nxt;
  logic [ROW_W-1:0]  res_row_r, res_row_nxt;
  logic              use_mem_r, use_mem_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic              in_xfer;
  logic              notice;
  logic              tick;
  line_t             line;
  logic [POS_W-1:0]  idx;
  logic [POS_W-1:0]  last;
  logic              empty;
  logic              pend;
  logic              do_conv;
  logic              do_blank;
  logic              do_char;
  logic [VAL_W-1:0]  conv_val;
  logic              emit_go;
  logic              write_done;
  logic [CHAR_W-1:0] emit_char;
  logic [7:0]        wr_char;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [7:0]        mem_rdata;

  du_cmd_t           du_cmd;
  du_stat_t          du_stat;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // ---- decode of the current transfer ----
  always_comb begin
    in_xfer  = in_tvalid && in_tready;
    notice   = in_xfer && (in_tuser == OP_NOTICE);
    tick     = in_xfer && (in_tuser == OP_TICK) && (line_sel_r != LINE_NONE);
    line     = line_sel_r;
    idx      = '0;
    last     = '0;
    empty    = 1'b1;
    pend     = 1'b0;
    conv_val = speed_r;
    if (line_sel_r != LINE_NONE) begin
      idx   = wpos_r[line_sel_r];
      last  = slen_r[line_sel_r];
      empty = (idx >= clen_r[line_sel_r]);
      pend  = (line_sel_r == LINE_STEPS) ? steps_pend_r : angle_pend_r;
    end
    unique case (line_sel_r)
      LINE_STEPS: conv_val = in_tdata[63:32];
      LINE_ANGLE: conv_val = in_tdata[95:64];
      default:    conv_val = speed_r;
    endcase
    do_conv    = tick && empty && (idx >= last) && pend;
    do_blank   = tick && empty && (idx < last);
    do_char    = tick && !empty;
    emit_go    = !out_tvalid_r || out_tready;
    write_done = !neg_r && (dcnt_r == DCNT_W'(1));
    emit_char  = use_mem_r ? mem_rdata[CHAR_W-1:0] : CH_SPACE[CHAR_W-1:0];
    wr_char    = neg_r ? CH_MINUS : (CH_ZERO + 8'(dig_r[dcnt_r - DCNT_W'(1)]));
  end

  // ---- next state ----
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (do_conv) begin
          state_nxt = ST_CONV;
        end else if (do_blank || do_char) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT:  if (emit_go) state_nxt = ST_IDLE;
      ST_CONV:  if (du_stat.digit_vld && du_stat.last) state_nxt = ST_WRITE;
      ST_WRITE: if (write_done) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // ---- datapath and outputs ----
  always_comb begin
    line_sel_nxt   = line_sel_r;
    cur_line_nxt   = cur_line_r;
    wpos_nxt       = wpos_r;
    slen_nxt       = slen_r;
    clen_nxt       = clen_r;
    steps_pend_nxt = steps_pend_r;
    angle_pend_nxt = angle_pend_r;
    speed_nxt      = speed_r;
    neg_nxt        = neg_r;
    dig_nxt        = dig_r;
    dcnt_nxt       = dcnt_r;
    wr_pos_nxt     = wr_pos_r;
    res_col_nxt    = res_col_r;
    res_row_nxt    = res_row_r;
    use_mem_nxt    = use_mem_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    mem_we         = 1'b0;
    mem_waddr      = ADDR_W'(cur_line_r) * ADDR_W'(STRING_LENGTH) + ADDR_W'(wr_pos_r);
    mem_re         = do_char;
    mem_raddr      = ADDR_W'(line) * ADDR_W'(STRING_LENGTH) + ADDR_W'(idx);
    du_cmd.start   = do_conv;
    du_cmd.value   = conv_val;

    unique case (state_r)
      ST_IDLE: begin
        if (notice) begin
          speed_nxt      = in_tdata[31:0];
          steps_pend_nxt = 1'b1;
          angle_pend_nxt = 1'b1;
        end else if (in_xfer) begin
          line_sel_nxt = (line == LINE_ANGLE || line == LINE_NONE) ? LINE_STEPS
                                                                   : line + 2'd1;
        end
        res_row_nxt = line_row(line);
        if (do_conv) begin
          slen_nxt[line] = idx;
          wpos_nxt[line] = '0;
          clen_nxt[line] = '0;
          cur_line_nxt   = line;
          neg_nxt        = conv_val[VAL_W-1];
          dcnt_nxt       = '0;
          wr_pos_nxt     = '0;
          if (line == LINE_STEPS) steps_pend_nxt = 1'b0;
          if (line == LINE_ANGLE) angle_pend_nxt = 1'b0;
        end else if (do_blank) begin
          res_col_nxt    = COL_W'(last) + BLANK_OFFSET;
          slen_nxt[line] = last - POS_W'(1);
          use_mem_nxt    = 1'b0;
        end else if (do_char) begin
          res_col_nxt    = COL_W'(idx) + FIRST_COLUMN;
          wpos_nxt[line] = idx + POS_W'(1);
          use_mem_nxt    = 1'b1;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {emit_char, res_row_r, res_col_r};
        end
      end
      ST_CONV: begin
        if (du_stat.digit_vld) begin
          dig_nxt[dcnt_r] = du_stat.digit;
          dcnt_nxt        = dcnt_r + DCNT_W'(1);
        end
      end
      ST_WRITE: begin
        mem_we     = 1'b1;
        wr_pos_nxt = wr_pos_r + POS_W'(1);
        if (neg_r) begin
          neg_nxt = 1'b0;
        end else begin
          dcnt_nxt = dcnt_r - DCNT_W'(1);
        end
        if (write_done) begin
          clen_nxt[cur_line_r] = wr_pos_r + POS_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      line_sel_r   <= LINE_STEPS;
      wpos_r       <= '{default: '0};
      slen_r       <= '{default: '0};
      clen_r       <= '{default: '0};
      steps_pend_r <= 1'b1;
      angle_pend_r <= 1'b1;
      speed_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      line_sel_r   <= line_sel_nxt;
      wpos_r       <= wpos_nxt;
      slen_r       <= slen_nxt;
      clen_r       <= clen_nxt;
      steps_pend_r <= steps_pend_nxt;
      angle_pend_r <= angle_pend_nxt;
      speed_r      <= speed_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_line_r  <= cur_line_nxt;
    neg_r       <= neg_nxt;
    dig_r       <= dig_nxt;
    dcnt_r      <= dcnt_nxt;
    wr_pos_r    <= wr_pos_nxt;
    res_col_r   <= res_col_nxt;
    res_row_r   <= res_row_nxt;
    use_mem_r   <= use_mem_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  dlr_text_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_text_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (wr_char),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  dlr_digit_unit u_digit_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (du_cmd),
    .stat  (du_stat)
  );

  // ---- assertions ----
  a_unit_idle_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_EMIT) |-> !du_stat.busy)
    else $error("digit unit busy outside conversion");

  a_pos_within_text: assert property (@(posedge clk) disable iff (!rst_n)
    (wpos_r[0] <= clen_r[0]) && (wpos_r[1] <= clen_r[1]) && (wpos_r[2] <= clen_r[2]))
    else $error("write position beyond stored text");

  a_text_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(clen_r[0]) < STRING_LENGTH) && (32'(clen_r[1]) < STRING_LENGTH) &&
    (32'(clen_r[2]) < STRING_LENGTH))
    else $error("stored text longer than line");

  a_round_robin_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_tuser == OP_TICK && line_sel_r == LINE_ANGLE) |=>
    (line_sel_r == LINE_STEPS))
    else $error("line select did not wrap to steps line");

endmodule

`default_nettype wire

// File: tb/sv/tb_display_line_refresher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_display_line_refresher
// Streams refresh ticks and new-value notices into the line refresher. A
// behavioral copy of the three text lines predicts every character write,
// and each out transfer is checked field by field against it. Both sides
// idle in random bursts; the tail of the run is idle-free.
// ----------------------------------------------------------------------------

module tb_display_line_refresher
  import dlr_pkg::*;
();

  localparam int SL          = DLR_STRING_LENGTH;
  localparam int RANDOM_ITEMS = 500;
  localparam int CALM_TAIL   = 60;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [VAL_W-1:0] VAL_MAX  = 32'h7fff_ffff;
  localparam logic [VAL_W-1:0] VAL_MIN  = 32'h8000_0000;
  localparam logic [VAL_W-1:0] VAL_NMAX = 32'h8000_0001;

  typedef struct {
    logic             op;
    logic [VAL_W-1:0] speed;
    logic [VAL_W-1:0] steps;
    logic [VAL_W-1:0] angle;
  } refresh_item_t;

  typedef struct {
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
    logic [CHAR_W-1:0] character;
  } char_write_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic                  in_tuser = OP_TICK;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  display_line_refresher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // line model
  logic [7:0]         line_text [3][SL];
  logic [POS_W-1:0]   cursor [3];
  logic [POS_W-1:0]   old_len [3];
  logic               steps_due;
  logic               angle_due;
  line_t              turn;
  logic [VAL_W-1:0]   speed_hold;
  logic [ROW_W-1:0]   row_of [3] = '{3'd5, 3'd7, 3'd6};

  refresh_item_t item_q [$];
  char_write_t   char_writes_due [$];
  refresh_item_t cur_item;
  int            errors = 0;
  int            cycles = 0;
  int            in_gap = 0;
  int            out_gap = 0;
  logic          calm = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    errors++;
  endtask

  task automatic render_number(input int li, input logic [VAL_W-1:0] v);
    logic [7:0]       digs [12];
    logic [VAL_W-1:0] mag;
    logic [7:0]       d;
    int               n;
    int               p;
    mag = v[VAL_W-1] ? (32'd0 - v) : v;
    n = 0;
    p = 0;
    do begin
      d = 8'(mag % 10);
      digs[n] = CH_ZERO + d;
      n++;
      mag = mag / 10;
    end while (mag != 0 && n < 12);
    if (v[VAL_W-1] && p < SL - 1) begin
      line_text[li][p] = CH_MINUS;
      p++;
    end
    while (n > 0 && p < SL - 1) begin
      n--;
      line_text[li][p] = digs[n];
      p++;
    end
    line_text[li][p] = 8'h00;
  endtask

  task automatic refresh_line_model(input refresh_item_t it);
    int               li;
    logic [POS_W-1:0] idx;
    logic [POS_W-1:0] last;
    logic [7:0]       ch;
    logic             due;
    logic [VAL_W-1:0] v;
    char_write_t      w;
    if (it.op == OP_NOTICE) begin
      speed_hold = it.speed;
      steps_due = 1'b1;
      angle_due = 1'b1;
      return;
    end
    if (turn == LINE_NONE) begin
      turn = LINE_STEPS;
      return;
    end
    li = turn;
    idx = cursor[li];
    last = old_len[li];
    ch = (idx < SL) ? line_text[li][idx] : 8'h00;
    if (ch == 8'h00 && idx >= last) begin
      due = (turn == LINE_STEPS) ? steps_due : angle_due;
      if (due) begin
        case (turn)
          LINE_STEPS: v = it.steps;
          LINE_SPEED: v = speed_hold;
          default:    v = it.angle;
        endcase
        render_number(li, v);
        old_len[li] = idx;
        cursor[li] = '0;
        if (turn == LINE_STEPS) steps_due = 1'b0;
        else if (turn == LINE_ANGLE) angle_due = 1'b0;
      end
    end else if (ch == 8'h00) begin
      w.column = last + BLANK_OFFSET;
      w.row = row_of[li];
      w.character = CH_SPACE[CHAR_W-1:0];
      char_writes_due.push_back(w);
      old_len[li] = last - 1'b1;
    end else begin
      w.column = idx + FIRST_COLUMN;
      w.row = row_of[li];
      w.character = ch[CHAR_W-1:0];
      char_writes_due.push_back(w);
      cursor[li] = idx + 1'b1;
    end
    turn = (turn == LINE_ANGLE) ? LINE_STEPS : line_t'(turn + 1'b1);
  endtask

  task automatic push_item(input logic op, input logic [VAL_W-1:0] speed,
                           input logic [VAL_W-1:0] steps, input logic [VAL_W-1:0] angle);
    refresh_item_t it;
    it.op = op;
    it.speed = speed;
    it.steps = steps;
    it.angle = angle;
    item_q.push_back(it);
  endtask

  // mix of short and long strings so shorter values blank out longer ones
  function automatic logic [VAL_W-1:0] pick_value();
    logic [VAL_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom_range(0, 9);
      2: v = 32'd0 - $urandom_range(1, 9);
      3: v = $urandom_range(0, 99999);
      4: v = 32'd0 - $urandom_range(1, 99999);
      default: begin
        v = $urandom_range(1000000000, 2147483647);
        if ($urandom_range(0, 1)) v = 32'd0 - v;
      end
    endcase
    return v;
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) refresh_line_model(cur_item);
      calm = (item_q.size() < CALM_TAIL);
      if (!calm && in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(1, 15) - 1;
        in_tvalid <= 1'b0;
      end else if (item_q.size() > 0) begin
        cur_item = item_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {cur_item.angle, cur_item.steps, cur_item.speed};
        in_tuser <= cur_item.op;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    char_write_t w;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (char_writes_due.size() == 0) begin
          report_mismatch($sformatf("unexpected write tdata=%h", out_tdata));
        end else begin
          w = char_writes_due.pop_front();
          if (out_tdata[5:0] !== w.column)
            report_mismatch($sformatf("column %0d, want %0d", out_tdata[5:0], w.column));
          if (out_tdata[8:6] !== w.row)
            report_mismatch($sformatf("row %0d, want %0d", out_tdata[8:6], w.row));
          if (out_tdata[15:9] !== w.character)
            report_mismatch($sformatf("character %h, want %h", out_tdata[15:9],
                                      w.character));
        end
      end
      if (calm) begin
        out_tready <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(1, 15) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_display_line_refresher: errors");
      $finish;
    end
  end

  initial begin
    for (int l = 0; l < 3; l++) begin
      for (int c = 0; c < SL; c++) line_text[l][c] = 8'h00;
      cursor[l] = '0;
      old_len[l] = '0;
    end
    steps_due = 1'b1;
    angle_due = 1'b1;
    turn = LINE_STEPS;
    speed_hold = '0;

    // directed: extreme values, zero, sign handling, notices mid-write
    push_item(OP_TICK, 32'hffff_ffff, VAL_MIN, 32'd0);
    push_item(OP_TICK, 32'd0, VAL_MAX, VAL_MAX);
    push_item(OP_TICK, 32'd0, 32'd0, VAL_NMAX);
    push_item(OP_NOTICE, VAL_MAX, 32'd0, 32'd0);
    for (int k = 0; k < 8; k++) push_item(OP_TICK, 32'd0, 32'd0, 32'd0);
    push_item(OP_NOTICE, 32'hffff_ffff, 32'd0, 32'd0);
    for (int k = 0; k < 6; k++) push_item(OP_TICK, VAL_MIN, 32'd0, 32'd5);
    push_item(OP_NOTICE, 32'd0, VAL_MIN, VAL_MIN);
    for (int k = 0; k < 6; k++) push_item(OP_TICK, 32'hffff_ffff, 32'd1, 32'hffff_ffff);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if ($urandom_range(0, 24) == 0)
        push_item(OP_NOTICE, pick_value(), $urandom, $urandom);
      else
        push_item(OP_TICK, $urandom, pick_value(), pick_value());
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (item_q.size() > 0 || in_tvalid) @(posedge clk);
    while (char_writes_due.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (char_writes_due.size() != 0)
      report_mismatch($sformatf("%0d writes never arrived", char_writes_due.size()));
    if (errors == 0) begin
      $display("tb_display_line_refresher: clean");
    end else begin
      $display("tb_display_line_refresher: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/dlr_pkg.sv
sv/dlr_text_mem.sv
sv/dlr_digit_unit.sv
sv/display_line_refresher.sv
tb/sv/tb_display_line_refresher.sv
